// File: hdl/bmms_pkg.sv
// ----------------------------------------------------------------------------
// bmms_pkg
// shared codes and field widths of the block matching motion search core
// ----------------------------------------------------------------------------
package bmms_pkg;

   // request kinds carried on tuser
   localparam logic [1:0] FUNC_LOAD_REF = 2'd0;
   localparam logic [1:0] FUNC_LOAD_WIN = 2'd1;
   localparam logic [1:0] FUNC_SEARCH   = 2'd2;

   // register indexes on the csr port
   localparam logic [2:0] CSR_REG_FACTOR   = 3'd0;
   localparam logic [2:0] CSR_SEARCH_RANGE = 3'd1;
   localparam logic [2:0] CSR_BLOCK_SIZE   = 3'd2;
   localparam logic [2:0] CSR_IMAGE_WIDTH  = 3'd3;
   localparam logic [2:0] CSR_IMAGE_HEIGHT = 3'd4;

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 48;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [31:0] COST_NONE = 32'h7FFF_FFFF;

   typedef logic signed [15:0] coord_type;

endpackage

// File: hdl/block_match_motion_search_core.sv
// ----------------------------------------------------------------------------
// block_match_motion_search_core
// full search block matcher, sum of squared differences plus distance penalty
// ----------------------------------------------------------------------------
//
//  channel | dir | word
//  req_    | in  | tuser: func; tdata: pixel_index, pixel_value, block_col,
//          |     |        block_row, hint_dx, hint_dy
//  rsp_    | out | tdata: best_dx, best_dy, best_cost, zero pad
//  csr_    | in  | write enable, register index, write data
//
//  a load is written straight into its store and the block stays ready
//  a search walks every candidate pixel by pixel through the single
//  squarer and accumulator and skips pixel columns outside the image;
//  a candidate whose rows leave the image is dropped; the hint
//  is scored first, then (2r+1)^2 - 1 offsets
//  reset is synchronous and clears control state and registers only
//  a finished result waits in the output register; the next search
//  finishes only once that word is taken
//
module block_match_motion_search_core #(
   parameter int BLOCK_MAX = 16,
   parameter int RANGE_MAX = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // func
   input  logic [1:0]                          req_tuser,
   // pixel_index, pixel_value, block_col, block_row, hint_dx, hint_dy
   input  logic [bmms_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // best_dx, best_dy, best_cost, one zero bit
   output logic [bmms_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_we,
   input  logic [bmms_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [bmms_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import bmms_pkg::*;

   localparam int WIN       = BLOCK_MAX + 2 * RANGE_MAX;
   localparam int REF_DEPTH = BLOCK_MAX * BLOCK_MAX;
   localparam int WIN_DEPTH = WIN * WIN;
   localparam int RAW       = $clog2(REF_DEPTH) > 0 ? $clog2(REF_DEPTH) : 1;
   localparam int WAW       = $clog2(WIN_DEPTH);
   localparam int CW        = $clog2(BLOCK_MAX + 1);
   localparam int DW        = $clog2(RANGE_MAX) + 2;

   // sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SETUP = 4'd1;
   localparam logic [3:0] S_CAND  = 4'd2;
   localparam logic [3:0] S_PIX   = 4'd3;
   localparam logic [3:0] S_MUL   = 4'd4;
   localparam logic [3:0] S_ACC   = 4'd5;
   localparam logic [3:0] S_DSQ   = 4'd6;
   localparam logic [3:0] S_PEN   = 4'd7;
   localparam logic [3:0] S_CMP   = 4'd8;
   localparam logic [3:0] S_NEXT  = 4'd9;
   localparam logic [3:0] S_DONE  = 4'd10;

   // input fields
   logic [11:0]       f_index;
   logic [11:0]       f_value;
   logic [7:0]        f_col;
   logic [7:0]        f_row;
   logic signed [7:0] f_hdx;
   logic signed [7:0] f_hdy;
   assign f_index = req_tdata[11:0];
   assign f_value = req_tdata[23:12];
   assign f_col   = req_tdata[31:24];
   assign f_row   = req_tdata[39:32];
   assign f_hdx   = req_tdata[47:40];
   assign f_hdy   = req_tdata[55:48];

   // configuration registers
   logic [15:0] reg_factor_ff;
   logic [4:0]  search_range_ff;
   logic [4:0]  block_size_ff;
   logic [12:0] image_width_ff;
   logic [12:0] image_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         reg_factor_ff   <= 16'd1280;
         search_range_ff <= 5'd16;
         block_size_ff   <= 5'd16;
         image_width_ff  <= 13'd1024;
         image_height_ff <= 13'd768;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_REG_FACTOR:   reg_factor_ff   <= csr_wdata;
            CSR_SEARCH_RANGE: search_range_ff <= csr_wdata[4:0];
            CSR_BLOCK_SIZE:   block_size_ff   <= csr_wdata[4:0];
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata[12:0];
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata[12:0];
            default: ;
         endcase
      end
   end

   // sequencer and datapath registers
   logic [3:0]           state_ff, state_in;
   logic [CW-1:0]        bs_ff, bs_in;
   logic signed [DW-1:0] r_ff, r_in;
   logic [7:0]           col_ff, col_in;
   logic [7:0]           row_ff, row_in;
   coord_type            top_ff, top_in;
   coord_type            left_ff, left_in;
   logic signed [7:0]    hx_ff, hx_in;
   logic signed [7:0]    hy_ff, hy_in;
   logic signed [DW-1:0] dx_ff, dx_in;
   logic signed [DW-1:0] dy_ff, dy_in;
   logic                 hint_ff, hint_in;
   logic signed [8:0]    tdx_ff, tdx_in;
   logic signed [8:0]    tdy_ff, tdy_in;
   logic [CW-1:0]        ry_ff, ry_in;
   logic [CW-1:0]        rx_ff, rx_in;
   logic [31:0]          ssd_ff, ssd_in;
   logic [25:0]          sq_ff, sq_in;
   logic [11:0]          dsq_ff, dsq_in;
   logic [31:0]          pen_ff, pen_in;
   logic [31:0]          best_ff, best_in;
   logic signed [7:0]    bx_ff, bx_in;
   logic signed [7:0]    by_ff, by_in;
   logic [31:0]          running_best_ff, running_best_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // memories
   logic [11:0]    ref_mem [REF_DEPTH];
   logic [11:0]    win_mem [WIN_DEPTH];
   logic [11:0]    ref_rd_ff;
   logic [11:0]    win_rd_ff;
   logic [RAW-1:0] ref_ra;
   logic [WAW-1:0] win_ra;

   logic req_fire;
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (req_fire && req_tuser == FUNC_LOAD_REF && 32'(f_index) < REF_DEPTH) begin
         ref_mem[RAW'(f_index)] <= f_value;
      end
      if (req_fire && req_tuser == FUNC_LOAD_WIN && 32'(f_index) < WIN_DEPTH) begin
         win_mem[WAW'(f_index)] <= f_value;
      end
      ref_rd_ff <= ref_mem[ref_ra];
      win_rd_ff <= win_mem[win_ra];
   end

   // geometry of the current pixel
   coord_type refy, srcy, refx, srcx, wrow, wcol;
   logic      row_bad, col_bad;
   logic signed [12:0] diff;
   logic signed [31:0] cost_sum;

   always_comb begin
      refy    = top_ff + coord_type'(ry_ff);
      srcy    = refy + coord_type'(tdy_ff);
      refx    = left_ff + coord_type'(rx_ff);
      srcx    = refx + coord_type'(tdx_ff);
      row_bad = (refy >= coord_type'(image_height_ff)) || (srcy < 0)
             || (srcy >= coord_type'(image_height_ff));
      col_bad = (refx >= coord_type'(image_width_ff)) || (srcx < 0)
             || (srcx >= coord_type'(image_width_ff));
      wrow    = coord_type'(ry_ff) + coord_type'(dy_ff) + coord_type'(RANGE_MAX);
      wcol    = coord_type'(rx_ff) + coord_type'(dx_ff) + coord_type'(RANGE_MAX);
      ref_ra  = RAW'(32'(ry_ff) * BLOCK_MAX + 32'(rx_ff));
      win_ra  = WAW'(32'(wrow) * WIN + 32'(wcol));
      diff    = $signed({1'b0, ref_rd_ff}) - $signed({1'b0, win_rd_ff});
      cost_sum = $signed(ssd_ff + pen_ff);
   end

   always_comb begin
      state_in        = state_ff;
      bs_in           = bs_ff;
      r_in            = r_ff;
      col_in          = col_ff;
      row_in          = row_ff;
      top_in          = top_ff;
      left_in         = left_ff;
      hx_in           = hx_ff;
      hy_in           = hy_ff;
      dx_in           = dx_ff;
      dy_in           = dy_ff;
      hint_in         = hint_ff;
      tdx_in          = tdx_ff;
      tdy_in          = tdy_ff;
      ry_in           = ry_ff;
      rx_in           = rx_ff;
      ssd_in          = ssd_ff;
      sq_in           = sq_ff;
      dsq_in          = dsq_ff;
      pen_in          = pen_ff;
      best_in         = best_ff;
      bx_in           = bx_ff;
      by_in           = by_ff;
      running_best_in = running_best_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_data_in     = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && req_tuser == FUNC_SEARCH) begin
               // clamp oversized settings
               bs_in  = (32'(block_size_ff) > BLOCK_MAX) ? CW'(BLOCK_MAX)
                                                          : CW'(block_size_ff);
               r_in   = (32'(search_range_ff) > RANGE_MAX) ? DW'(RANGE_MAX)
                                                             : DW'(search_range_ff);
               col_in  = f_col;
               row_in  = f_row;
               hx_in   = f_hdx;
               hy_in   = f_hdy;
               bx_in   = f_hdx;
               by_in   = f_hdy;
               best_in = COST_NONE;
               dx_in   = '0;
               dy_in   = '0;
               hint_in = 1'b1;
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            top_in   = coord_type'(row_ff * bs_ff);
            left_in  = coord_type'(col_ff * bs_ff);
            state_in = S_CAND;
         end
         S_CAND: begin
            tdx_in = 9'(hx_ff) + 9'(dx_ff);
            tdy_in = 9'(hy_ff) + 9'(dy_ff);
            ssd_in = '0;
            ry_in  = '0;
            rx_in  = '0;
            // origin already scored as the hint
            if (!hint_ff && dx_ff == 0 && dy_ff == 0) begin
               state_in = S_NEXT;
            end else begin
               state_in = S_PIX;
            end
         end
         S_PIX: begin
            priority if (tdx_ff < -128 || tdx_ff > 127 || tdy_ff < -128 || tdy_ff > 127) begin
               state_in = S_NEXT;
            end else if (ry_ff == bs_ff) begin
               state_in = S_DSQ;
            end else if (rx_ff == bs_ff) begin
               ry_in = ry_ff + 1'b1;
               rx_in = '0;
            end else if (rx_ff == '0 && row_bad) begin
               state_in = S_NEXT;
            end else if (col_bad) begin
               rx_in = rx_ff + 1'b1;
            end else begin
               // memory read issued at this edge
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            sq_in    = 26'(diff * diff);
            rx_in    = rx_ff + 1'b1;
            state_in = S_ACC;
         end
         S_ACC: begin
            ssd_in   = ssd_ff + 32'(sq_ff[25:8]);
            state_in = S_PIX;
         end
         S_DSQ: begin
            dsq_in   = 12'(dx_ff * dx_ff) + 12'(dy_ff * dy_ff);
            state_in = S_PEN;
         end
         S_PEN: begin
            pen_in   = hint_ff ? 32'd0 : 32'((28'(reg_factor_ff) * 28'(dsq_ff)) >> 8);
            state_in = S_CMP;
         end
         S_CMP: begin
            if (unsigned'(cost_sum) < best_ff) begin
               best_in = unsigned'(cost_sum);
               bx_in   = tdx_ff[7:0];
               by_in   = tdy_ff[7:0];
            end
            state_in = S_NEXT;
         end
         S_NEXT: begin
            priority if (hint_ff) begin
               hint_in  = 1'b0;
               dx_in    = -r_ff;
               dy_in    = -r_ff;
               state_in = S_CAND;
            end else if (dx_ff == r_ff && dy_ff == r_ff) begin
               state_in = S_DONE;
            end else if (dx_ff == r_ff) begin
               dx_in    = -r_ff;
               dy_in    = dy_ff + 1'b1;
               state_in = S_CAND;
            end else begin
               dx_in    = dx_ff + 1'b1;
               state_in = S_CAND;
            end
         end
         S_DONE: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in    = 1'b1;
               rsp_data_in     = {1'b0, best_ff[30:0], by_ff, bx_ff};
               running_best_in = best_ff;
               state_in        = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         rsp_valid_ff    <= 1'b0;
         running_best_ff <= '0;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         running_best_ff <= running_best_in;
      end
      bs_ff       <= bs_in;
      r_ff        <= r_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      top_ff      <= top_in;
      left_ff     <= left_in;
      hx_ff       <= hx_in;
      hy_ff       <= hy_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      hint_ff     <= hint_in;
      tdx_ff      <= tdx_in;
      tdy_ff      <= tdy_in;
      ry_ff       <= ry_in;
      rx_ff       <= rx_in;
      ssd_ff      <= ssd_in;
      sq_ff       <= sq_in;
      dsq_ff      <= dsq_in;
      pen_ff      <= pen_in;
      best_ff     <= best_in;
      bx_ff       <= bx_in;
      by_ff       <= by_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: hdl/bmms_checker.sv
// ----------------------------------------------------------------------------
// bmms_checker
// port level checks of the block matching motion search core
// ----------------------------------------------------------------------------
module bmms_checker (
   input logic                            clock,
   input logic                            reset,
   input logic [1:0]                      req_tuser,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [bmms_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready
);
   import bmms_pkg::*;

   // nothing pending right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word after reset");

   // held result word stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word dropped or changed while stalled");

   // a search keeps the block busy
   a_search_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == FUNC_SEARCH |=> !req_tready)
      else $error("ready right after search start");

   // loads and ignored request kinds never block the next word
   a_load_ready: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser != FUNC_SEARCH |=> req_tready)
      else $error("not ready after load");

   // no new result word shows right after an accepted request
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("result word without search");

endmodule

bind block_match_motion_search_core bmms_checker u_bmms_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tuser  (req_tuser),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

// File: tb/block_match_motion_search_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// block_match_motion_search_core_test
// self-checking bench: loads both stores, runs searches under several
// register settings and handshake idling modes, predicts every result word
// ----------------------------------------------------------------------------

typedef struct packed {
   logic signed [7:0] dx;
   logic signed [7:0] dy;
   logic [30:0]       cost;
} motion_word_type;

class motion_scoreboard;
   logic [11:0]     ref_px [256];
   logic [11:0]     win_px [2304];
   int unsigned     regs [5];
   motion_word_type pending_q [$];
   int              errors;
   int              searches;
   int              loads;
   int              results;

   function new();
      regs[bmms_pkg::CSR_REG_FACTOR]   = 1280;
      regs[bmms_pkg::CSR_SEARCH_RANGE] = 16;
      regs[bmms_pkg::CSR_BLOCK_SIZE]   = 16;
      regs[bmms_pkg::CSR_IMAGE_WIDTH]  = 1024;
      regs[bmms_pkg::CSR_IMAGE_HEIGHT] = 768;
   endfunction

   function void set_reg(int idx, int unsigned val);
      case (idx)
         bmms_pkg::CSR_REG_FACTOR:   regs[idx] = val & 16'hFFFF;
         bmms_pkg::CSR_SEARCH_RANGE: regs[idx] = val & 5'h1F;
         bmms_pkg::CSR_BLOCK_SIZE:   regs[idx] = val & 5'h1F;
         bmms_pkg::CSR_IMAGE_WIDTH:  regs[idx] = val & 13'h1FFF;
         bmms_pkg::CSR_IMAGE_HEIGHT: regs[idx] = val & 13'h1FFF;
         default: ;
      endcase
   endfunction

   // ssd of one displacement relative to the hint, 0 when invalid
   function bit score_at(int bs, int top, int left, int hx, int hy, int dx, int dy,
                         output longint ssd);
      int tdx, tdy, ref_y, src_y, ref_x, src_x, a, b, w, h;
      tdx = hx + dx;
      tdy = hy + dy;
      w = int'(regs[bmms_pkg::CSR_IMAGE_WIDTH]);
      h = int'(regs[bmms_pkg::CSR_IMAGE_HEIGHT]);
      ssd = 0;
      if (tdx < -128 || tdx > 127 || tdy < -128 || tdy > 127) return 0;
      for (int ry = 0; ry < bs; ry++) begin
         ref_y = top + ry;
         src_y = ref_y + tdy;
         if (ref_y >= h || src_y < 0 || src_y >= h) return 0;
         for (int rx = 0; rx < bs; rx++) begin
            ref_x = left + rx;
            src_x = ref_x + tdx;
            if (ref_x >= w || src_x < 0 || src_x >= w) continue;
            a = ref_px[ry*16 + rx];
            b = win_px[(ry + dy + 16)*48 + rx + dx + 16];
            ssd += ((a - b) * (a - b)) >> 8;
         end
      end
      return 1;
   endfunction

   function void note_req(logic [1:0] func, logic [55:0] data);
      int bs, r, left, top, hx, hy, bx, by;
      longint best, ssd, cost;
      motion_word_type w;
      if (func == bmms_pkg::FUNC_LOAD_REF) begin
         loads++;
         if (data[11:0] < 256) ref_px[data[11:0]] = data[23:12];
      end else if (func == bmms_pkg::FUNC_LOAD_WIN) begin
         loads++;
         if (data[11:0] < 2304) win_px[data[11:0]] = data[23:12];
      end else if (func == bmms_pkg::FUNC_SEARCH) begin
         searches++;
         bs = regs[bmms_pkg::CSR_BLOCK_SIZE] > 16 ? 16 : regs[bmms_pkg::CSR_BLOCK_SIZE];
         r = regs[bmms_pkg::CSR_SEARCH_RANGE] > 16 ? 16 : regs[bmms_pkg::CSR_SEARCH_RANGE];
         left = int'(data[31:24]) * bs;
         top = int'(data[39:32]) * bs;
         hx = $signed(data[47:40]);
         hy = $signed(data[55:48]);
         bx = hx;
         by = hy;
         best = bmms_pkg::COST_NONE;
         if (score_at(bs, top, left, hx, hy, 0, 0, ssd)) best = ssd;
         for (int dy = -r; dy <= r; dy++)
            for (int dx = -r; dx <= r; dx++) begin
               if (dx == 0 && dy == 0) continue;
               if (!score_at(bs, top, left, hx, hy, dx, dy, ssd)) continue;
               cost = ssd + ((longint'(regs[bmms_pkg::CSR_REG_FACTOR]) * (dx*dx + dy*dy)) >> 8);
               if (cost < best) begin
                  best = cost;
                  bx = hx + dx;
                  by = hy + dy;
               end
            end
         w.dx = bx[7:0];
         w.dy = by[7:0];
         w.cost = best[30:0];
         pending_q = {pending_q, w};
      end
   endfunction

   task report(string what);
      $display("%t mismatch: %s", $realtime, what);
      errors++;
   endtask

   task check_rsp(logic [47:0] data);
      motion_word_type w;
      results++;
      if (pending_q.size() == 0) begin
         report($sformatf("unexpected word %h", data));
         return;
      end
      w = pending_q.pop_front();
      if (data[7:0] !== w.dx)
         report($sformatf("best_dx %0d, predicted %0d", $signed(data[7:0]), w.dx));
      if (data[15:8] !== w.dy)
         report($sformatf("best_dy %0d, predicted %0d", $signed(data[15:8]), w.dy));
      if (data[46:16] !== w.cost)
         report($sformatf("best_cost %0d, predicted %0d", data[46:16], w.cost));
   endtask
endclass

module block_match_motion_search_core_test;
   import bmms_pkg::*;

   localparam int IDLE_LIMIT = 50000;
   localparam int SETTLE = 20;
   // request kind the block ignores
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   logic                  clock;
   logic                  reset;
   // func
   logic [1:0]            req_tuser;
   // pixel_index, pixel_value, block_col, block_row, hint_dx, hint_dy
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tvalid;
   logic                  req_tready;
   // best_dx, best_dy, best_cost, zero bit
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   motion_scoreboard sb = new();
   int send_idle;      // percent of cycles the sender holds off
   int recv_stall;     // percent of cycles the receiver stalls
   int quiet_cycles;

   block_match_motion_search_core u_dut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // receiver: random stall, check each accepted word
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall);
      if (!reset && rsp_tvalid && rsp_tready) sb.check_rsp(rsp_tdata);
   end

   // watchdog on cycles without any accepted word
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > IDLE_LIMIT) begin
         $display("watchdog expired with %0d words outstanding", sb.pending_q.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // one request word; valid stays high across back-to-back words
   task automatic send_req(input logic [1:0] func, input logic [55:0] data);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_req(func, data);
   endtask

   task automatic send_load(input logic [1:0] func, input int idx, input int px);
      send_req(func, {32'd0, px[11:0], idx[11:0]});
   endtask

   task automatic send_search(input int col, input int row, input int hx, input int hy);
      send_req(FUNC_SEARCH, {hy[7:0], hx[7:0], row[7:0], col[7:0], 24'd0});
   endtask

   // wait until every predicted word is back, then let the block settle
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // all five registers, one per cycle; only called while idle
   task automatic write_regs(input int rf, input int sr, input int bsz, input int w,
                             input int h);
      int vals[5];
      vals = '{rf, sr, bsz, w, h};
      for (int i = 0; i < 5; i++) begin
         csr_we <= 1'b1;
         csr_addr <= i[CSR_ADDR_W-1:0];
         csr_wdata <= vals[i][15:0];
         sb.set_reg(i, vals[i]);
         @(posedge clock);
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_phase(input int idle, input int stall, input int n);
      int bsz, rng, w, h, col, row, f;
      send_idle = idle;
      recv_stall = stall;
      bsz = $urandom_range(1, 4);
      rng = $urandom_range(1, 3);
      w = $urandom_range(8, 300);
      h = $urandom_range(8, 300);
      write_regs($urandom_range(0, 65535), rng, bsz, w, h);
      for (int i = 0; i < n; i++) begin
         f = $urandom_range(99);
         if (f < 12) begin
            if ($urandom_range(9) == 0) begin
               col = $urandom_range(0, 255);
               row = $urandom_range(0, 255);
            end else begin
               col = $urandom_range(0, w / bsz);
               row = $urandom_range(0, h / bsz);
            end
            if ($urandom_range(9) == 0)
               send_search(col, row, $urandom_range(0, 255), $urandom_range(0, 255));
            else
               send_search(col, row, $urandom_range(0, 10) - 5, $urandom_range(0, 10) - 5);
         end else if (f < 14) begin
            send_req(FUNC_UNUSED, 56'({$urandom, $urandom}));
         end else if (f < 50) begin
            send_load(FUNC_LOAD_REF, $urandom_range(0, 300), $urandom_range(0, 4095));
         end else begin
            send_load(FUNC_LOAD_WIN, $urandom_range(0, 4095), $urandom_range(0, 4095));
         end
      end
      drain();
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid <= 1'b0;
      req_tuser <= '0;
      req_tdata <= '0;
      csr_we <= 1'b0;
      csr_addr <= '0;
      csr_wdata <= '0;
      send_idle = 0;
      recv_stall = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill every pixel that a search below can reach
      // reference: first four columns of all rows
      for (int ry = 0; ry < 16; ry++)
         for (int rx = 0; rx < 4; rx++)
            send_load(FUNC_LOAD_REF, ry*16 + rx,
                      (rx == ry) ? 4095 * (ry % 2) : $urandom_range(0, 4095));
      // window: square around the center for small blocks and ranges
      for (int wy = 13; wy < 23; wy++)
         for (int wx = 13; wx < 23; wx++)
            send_load(FUNC_LOAD_WIN, wy*48 + wx,
                      (wx == wy) ? 4095 * ((wy + 1) % 2) : $urandom_range(0, 4095));
      // window: center columns over rows 0 to 32 for tall searches
      for (int wy = 0; wy < 33; wy++)
         if (wy < 13 || wy > 22)
            for (int wx = 16; wx < 18; wx++)
               send_load(FUNC_LOAD_WIN, wy*48 + wx, $urandom_range(0, 4095));
      // ignored kinds: unknown func, addresses past each store
      send_req(FUNC_UNUSED, 56'hFF_FFFF_FFFF_FFFF);
      send_load(FUNC_LOAD_REF, 4095, 4095);
      send_load(FUNC_LOAD_WIN, 4095, 0);
      drain();

      // plain search, then hint near the displacement limits
      write_regs(1280, 2, 2, 64, 64);
      send_search(1, 1, 0, 0);
      send_search(3, 2, -1, 1);
      send_search(255, 255, -128, 127);
      send_search(0, 0, 127, -128);
      drain();
      // block reaching past the image edge, column skipping near the right edge
      write_regs(65535, 2, 3, 7, 4096);
      send_search(2, 1, 0, 0);
      send_search(1, 1, 2, 0);
      drain();
      // rows outside the image: nothing valid
      write_regs(0, 1, 2, 4096, 1);
      send_search(5, 5, 0, 0);
      send_search(0, 0, 0, 0);
      drain();
      // zero block size: hint wins at cost zero
      write_regs(300, 3, 0, 100, 100);
      send_search(4, 4, 3, -2);
      drain();
      // oversized block size saturates to the full block, narrow image
      write_regs(1280, 1, 31, 2, 8191);
      send_search(0, 0, 0, 0);
      drain();
      // oversized range saturates to the full radius, one column wide image
      write_regs(0, 31, 1, 1, 4096);
      send_search(0, 20, 0, 0);
      drain();
      // full radius at the top-left corner
      write_regs(65535, 16, 1, 1, 4096);
      send_search(0, 0, 0, 0);
      drain();

      random_phase(0, 0, 65);
      random_phase(71, 0, 65);
      random_phase(0, 71, 65);
      random_phase(28, 28, 65);

      $display("covered %0d pixel loads and %0d searches, %0d result words checked",
               sb.loads, sb.searches, sb.results);
      $display("settings swept from zero block size to saturated block and range");
      if (sb.errors == 0 && sb.pending_q.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches, %0d words never seen", sb.errors, sb.pending_q.size());
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// File: filelist.f
hdl/bmms_pkg.sv
hdl/block_match_motion_search_core.sv
hdl/bmms_checker.sv
tb/block_match_motion_search_core_test.sv
